### rtl/ksfq_pkg.sv
// ============================================================================
// ksfq_pkg: shared constants of the key signal filter queue
// key code assignments, action codes and register indexes of the block
// ============================================================================
`default_nettype none

package ksfq_pkg;

   // default ring depth (one slot always stays free)
   localparam int QUEUE_DEPTH_DEF = 128;

   // field widths
   localparam int KEY_W    = 9;
   localparam int ACTION_W = 4;
   localparam int CHAR_W   = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;

   // special key codes
   localparam logic [KEY_W-1:0] CODE_CTRL_C         = 9'd256;
   localparam logic [KEY_W-1:0] CODE_CTRL_Z         = 9'd257;
   localparam logic [KEY_W-1:0] CODE_CTRL_BACKSLASH = 9'd258;
   localparam logic [KEY_W-1:0] CODE_CTRL_S         = 9'd259;

   // control bytes of the ctrl key codes
   localparam logic [CHAR_W-1:0] BYTE_CTRL_C         = 8'h03;
   localparam logic [CHAR_W-1:0] BYTE_CTRL_Z         = 8'h1A;
   localparam logic [CHAR_W-1:0] BYTE_CTRL_BACKSLASH = 8'h1C;

   // register reset values
   localparam logic [CHAR_W-1:0] INTR_CHAR_RST = 8'd3;
   localparam logic [CHAR_W-1:0] QUIT_CHAR_RST = 8'd28;
   localparam logic [CHAR_W-1:0] SUSP_CHAR_RST = 8'd26;

   // request commands
   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_POP  = 1'b1;

   // action codes
   localparam logic [ACTION_W-1:0] ACT_IGNORED   = 4'd0;
   localparam logic [ACTION_W-1:0] ACT_QUEUED    = 4'd1;
   localparam logic [ACTION_W-1:0] ACT_FULL      = 4'd2;
   localparam logic [ACTION_W-1:0] ACT_SWALLOWED = 4'd3;
   localparam logic [ACTION_W-1:0] ACT_KILL      = 4'd4;
   localparam logic [ACTION_W-1:0] ACT_INTR      = 4'd5;
   localparam logic [ACTION_W-1:0] ACT_QUIT      = 4'd6;
   localparam logic [ACTION_W-1:0] ACT_SUSP      = 4'd7;
   localparam logic [ACTION_W-1:0] ACT_POPPED    = 4'd8;
   localparam logic [ACTION_W-1:0] ACT_EMPTY     = 4'd9;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GRAPHICS_MODE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ISIG_ENABLE   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INTR_CHAR     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_QUIT_CHAR     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SUSP_CHAR     = 3'd4;

endpackage

`default_nettype wire

### rtl/key_signal_filter_queue.sv
// ============================================================================
// key_signal_filter_queue: console keyboard signal filter and key queue
// filters interrupt, quit and suspend keys and queues the rest in a ring
// ============================================================================
// The block accepts a new request on every clock while results are drained:
// a request is decided from the ring pointers and the settings in the
// accepting cycle, passes a decision stage (where the key memory's
// registered read port delivers a popped key) and lands in the result
// register. The decision stage and the result register together let one
// result wait on a stalled result channel while the next request is still
// taken. The ring holds QUEUE_DEPTH-1 keys. Settings are written through
// the csr port, which is always ready; write them only while no request is
// in flight. The key memory needs no clearing after reset.
`default_nettype none

module key_signal_filter_queue #(
   parameter int QUEUE_DEPTH = ksfq_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic                              req_cmd,
   input  wire logic [ksfq_pkg::KEY_W-1:0]        req_key_code,
   // result channel
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [ksfq_pkg::ACTION_W-1:0]          rsp_action,
   output logic [ksfq_pkg::KEY_W-1:0]             rsp_key_out,
   // settings write channel
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [ksfq_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [ksfq_pkg::CSR_DATA_W-1:0]   csr_data
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

   // ---------------------------------------------------------------------
   // settings registers
   // ---------------------------------------------------------------------
   logic                               graphics_mode_ff;
   logic                               isig_enable_ff;
   logic [ksfq_pkg::CHAR_W-1:0]        intr_char_ff;
   logic [ksfq_pkg::CHAR_W-1:0]        quit_char_ff;
   logic [ksfq_pkg::CHAR_W-1:0]        susp_char_ff;
   logic                               csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         graphics_mode_ff <= 1'b0;
         isig_enable_ff   <= 1'b1;
         intr_char_ff     <= ksfq_pkg::INTR_CHAR_RST;
         quit_char_ff     <= ksfq_pkg::QUIT_CHAR_RST;
         susp_char_ff     <= ksfq_pkg::SUSP_CHAR_RST;
      end else if (csr_write) begin
         // unknown indexes fall through and change nothing
         unique case (csr_index)
            ksfq_pkg::CSR_GRAPHICS_MODE: graphics_mode_ff <= csr_data[0];
            ksfq_pkg::CSR_ISIG_ENABLE:   isig_enable_ff   <= csr_data[0];
            ksfq_pkg::CSR_INTR_CHAR:     intr_char_ff     <= csr_data;
            ksfq_pkg::CSR_QUIT_CHAR:     quit_char_ff     <= csr_data;
            ksfq_pkg::CSR_SUSP_CHAR:     susp_char_ff     <= csr_data;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // handshake of the two stages
   // ---------------------------------------------------------------------
   logic                               dec_valid_ff;
   logic                               dec_valid_in;
   logic                               rsp_valid_ff;
   logic                               rsp_valid_in;
   logic                               out_free;
   logic                               dec_move;
   logic                               req_take;

   // result register can load when empty or being drained this cycle
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign dec_move  = dec_valid_ff & out_free;
   // decision stage can load when empty or moving on
   assign req_stall = dec_valid_ff & ~out_free;
   assign req_take  = req_valid & ~req_stall;

   assign dec_valid_in = req_take | (dec_valid_ff & ~out_free);
   assign rsp_valid_in = dec_move | (rsp_valid_ff & rsp_stall);

   // ---------------------------------------------------------------------
   // ring pointers and request decision
   // ---------------------------------------------------------------------
   logic [PTR_W-1:0]                   wr_ptr_ff;
   logic [PTR_W-1:0]                   wr_ptr_in;
   logic [PTR_W-1:0]                   rd_ptr_ff;
   logic [PTR_W-1:0]                   rd_ptr_in;
   logic [PTR_W-1:0]                   wr_ptr_next;
   logic [PTR_W-1:0]                   rd_ptr_next;
   logic                               ring_empty;
   logic                               ring_full;
   logic                               has_byte;
   logic [ksfq_pkg::CHAR_W-1:0]        ctrl_byte;
   logic                               sig_check;
   logic [ksfq_pkg::ACTION_W-1:0]      action;
   logic                               mem_write;
   logic                               mem_read;

   // wrap at the depth, which need not be a power of two
   assign wr_ptr_next = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_ptr_next = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
   assign ring_empty  = (wr_ptr_ff == rd_ptr_ff);
   assign ring_full   = (wr_ptr_next == rd_ptr_ff);

   // control byte of the pushed key; codes above 127 other than the
   // ctrl codes carry none
   always_comb begin
      has_byte  = 1'b1;
      ctrl_byte = '0;
      priority if (req_key_code == ksfq_pkg::CODE_CTRL_C) begin
         ctrl_byte = ksfq_pkg::BYTE_CTRL_C;
      end else if (req_key_code == ksfq_pkg::CODE_CTRL_Z) begin
         ctrl_byte = ksfq_pkg::BYTE_CTRL_Z;
      end else if (req_key_code == ksfq_pkg::CODE_CTRL_BACKSLASH) begin
         ctrl_byte = ksfq_pkg::BYTE_CTRL_BACKSLASH;
      end else if (req_key_code[ksfq_pkg::KEY_W-1:7] == '0) begin
         ctrl_byte = {1'b0, req_key_code[6:0]};
      end else begin
         has_byte = 1'b0;
      end
   end

   assign sig_check = isig_enable_ff & has_byte;

   // action of the request; intr beats quit beats susp on equal characters
   always_comb begin
      action = ksfq_pkg::ACT_IGNORED;
      if (req_cmd == ksfq_pkg::CMD_POP) begin
         action = ring_empty ? ksfq_pkg::ACT_EMPTY : ksfq_pkg::ACT_POPPED;
      end else begin
         priority if (req_key_code == '0) begin
            action = ksfq_pkg::ACT_IGNORED;
         end else if (graphics_mode_ff) begin
            action = (req_key_code == ksfq_pkg::CODE_CTRL_S) ?
                     ksfq_pkg::ACT_KILL : ksfq_pkg::ACT_SWALLOWED;
         end else if (sig_check && ctrl_byte == intr_char_ff) begin
            action = ksfq_pkg::ACT_INTR;
         end else if (sig_check && ctrl_byte == quit_char_ff) begin
            action = ksfq_pkg::ACT_QUIT;
         end else if (sig_check && ctrl_byte == susp_char_ff) begin
            action = ksfq_pkg::ACT_SUSP;
         end else if (ring_full) begin
            action = ksfq_pkg::ACT_FULL;
         end else begin
            action = ksfq_pkg::ACT_QUEUED;
         end
      end
   end

   assign mem_write = req_take & (action == ksfq_pkg::ACT_QUEUED);
   assign mem_read  = req_take & (action == ksfq_pkg::ACT_POPPED);
   assign wr_ptr_in = mem_write ? wr_ptr_next : wr_ptr_ff;
   assign rd_ptr_in = mem_read  ? rd_ptr_next : rd_ptr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         dec_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         dec_valid_ff <= dec_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---------------------------------------------------------------------
   // key memory, one write and one registered read port
   // ---------------------------------------------------------------------
   logic [ksfq_pkg::KEY_W-1:0]         key_mem [QUEUE_DEPTH];
   logic [ksfq_pkg::KEY_W-1:0]         dec_key_ff;

   // read data only changes on a pop, so it holds while the stage waits
   always_ff @(posedge clock) begin
      if (mem_write) begin
         key_mem[wr_ptr_ff] <= req_key_code;
      end
      if (mem_read) begin
         dec_key_ff <= key_mem[rd_ptr_ff];
      end
   end

   // ---------------------------------------------------------------------
   // decision stage and result register
   // ---------------------------------------------------------------------
   logic [ksfq_pkg::ACTION_W-1:0]      dec_action_ff;
   logic [ksfq_pkg::ACTION_W-1:0]      rsp_action_ff;
   logic [ksfq_pkg::KEY_W-1:0]         rsp_key_out_ff;
   logic [ksfq_pkg::KEY_W-1:0]         rsp_key_out_in;

   assign rsp_key_out_in = (dec_action_ff == ksfq_pkg::ACT_POPPED) ? dec_key_ff : '0;

   always_ff @(posedge clock) begin
      if (req_take) begin
         dec_action_ff <= action;
      end
      if (dec_move) begin
         rsp_action_ff  <= dec_action_ff;
         rsp_key_out_ff <= rsp_key_out_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_action  = rsp_action_ff;
   assign rsp_key_out = rsp_key_out_ff;

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------

   // a key only leaves with a popped action
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_action_ff != ksfq_pkg::ACT_POPPED |-> rsp_key_out_ff == '0)
      else $error("key_out set on a result that is not a pop");

   // an empty report only comes with equal pointers
   assert property (@(posedge clock) disable iff (reset)
      req_take && action == ksfq_pkg::ACT_EMPTY |-> wr_ptr_ff == rd_ptr_ff)
      else $error("empty reported with keys in the ring");

   // a queued key moves the write pointer and leaves the read pointer
   assert property (@(posedge clock) disable iff (reset)
      mem_write |=> wr_ptr_ff != $past(wr_ptr_ff) && rd_ptr_ff == $past(rd_ptr_ff))
      else $error("queued key did not advance the write pointer");

   // the request side only stalls behind a held decision
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> dec_valid_ff && rsp_valid_ff)
      else $error("request stalled with room in the pipeline");

endmodule

`default_nettype wire
